// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge while reset is released.
`define ASSERT_RUN(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Property checked at every rising edge, during reset too.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== hdl/fsa_pkg.sv =====
`timescale 1ns / 1ps
package fsa_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int ADDR_W    = 48;
  localparam int CTR_W     = 32;
  localparam int OBJ_W     = 13;
  localparam int ALIGN_W   = 4;
  localparam int AL_W      = 13;
  localparam int STRIDE_W  = 14;
  localparam int OFF_W     = STRIDE_W + IDX_W - 1;
  localparam int LIMIT_W   = STRIDE_W + CNT_W;
  localparam int PROD_W    = STRIDE_W + IDX_W;
  localparam int STEP_W    = $clog2(IDX_W);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int CFG_IDX_W = 2;

  localparam logic [ALIGN_W-1:0] MAX_ALIGN_LOG2 = 4'd12;
  localparam logic [CNT_W-1:0]   MAX_CAP        = CNT_W'(MAX_SLOTS);
  localparam logic [CTR_W-1:0]   CTR_MAX        = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OBJECT_SIZE,
    REG_ALIGNMENT_LOG2,
    REG_POOL_CAPACITY,
    REG_BACKING_BASE
  } cfg_reg_t;

  typedef enum logic {
    OP_ACQUIRE,
    OP_RELEASE
  } op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_EMPTY,
    ST_NULL,
    ST_BAD_ADDR,
    ST_NOT_ACTIVE,
    ST_OVERFLOW
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ACQ_READ,
    BK_ACQ_ADD,
    BK_DIV,
    BK_REL
  } bk_state_t;

  typedef struct packed {
    op_t                operation;
    logic [ADDR_W-1:0]  release_address;
  } fsa_in_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  slot_addr;
    logic [CNT_W-1:0]   active_count;
    logic [CNT_W-1:0]   free_count;
    logic [CNT_W-1:0]   peak_count;
    logic [CTR_W-1:0]   allocation_total;
    logic [CTR_W-1:0]   release_total;
  } fsa_out_t;

  typedef struct packed {
    logic [STRIDE_W-1:0] stride;
    logic [ADDR_W-1:0]   region;
    logic [CNT_W-1:0]    cap;
    logic [LIMIT_W-1:0]  limit;
  } fsa_geom_t;

  typedef struct packed {
    op_t               operation;
    logic              is_null;
    logic              out_of_range;
    logic [OFF_W-1:0]  offset;
  } fsa_job_t;

endpackage

// ===== hdl/fixed_slot_pool_allocator.sv =====
`timescale 1ns / 1ps
// An acquire passes through the read and add states, a release through the
// stride divider (one quotient bit per cycle) and the in-use check, and a reject
// found at classification is answered from idle; each result is registered.
// The back end finishes one operation before it takes another from the queue; a two-entry queue buffers the front end.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Synchronous reset and every configuration write reinitialize the pool.
module fixed_slot_pool_allocator
  import fsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  fsa_in_t               in_data,
  output logic                  out_valid,
  output fsa_out_t              out_data
);

  logic      q_full;
  logic      q_empty;
  logic      push;
  logic      pop;
  logic      init;
  fsa_job_t  push_job;
  fsa_job_t  head_job;
  fsa_geom_t geom;

  fsa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .in_data   (in_data),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_job  (push_job),
    .geom      (geom),
    .init      (init)
  );

  fsa_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  fsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .init      (init),
    .geom      (geom),
    .q_empty   (q_empty),
    .q_job     (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/fsa_fifo.sv =====
`timescale 1ns / 1ps
module fsa_fifo
  import fsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  fsa_job_t push_job,
  input  logic     pop,
  output fsa_job_t head_job,
  output logic     empty,
  output logic     full
);

  fsa_job_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r;
  logic [QPTR_W-1:0]    rd_ptr_r;
  logic [QPTR_W:0]      count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (QPTR_W+1)'(QDEPTH));
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

// ===== hdl/fsa_front.sv =====
`timescale 1ns / 1ps
module fsa_front
  import fsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_wdata,
  input  logic                  start,
  input  fsa_in_t               in_data,
  input  logic                  q_full,
  output logic                  busy,
  output logic                  push,
  output fsa_job_t              push_job,
  output fsa_geom_t             geom,
  output logic                  init
);

  logic [OBJ_W-1:0]    obj_size_r;
  logic [ALIGN_W-1:0]  align_log2_r;
  logic [CNT_W-1:0]    capacity_r;
  logic [ADDR_W-1:0]   base_r;
  logic                settle_r;
  fsa_geom_t           geom_r;
  fsa_geom_t           geom_nxt;

  logic [ALIGN_W-1:0]  sh;
  logic [AL_W-1:0]     al;
  logic [STRIDE_W-1:0] mask;
  logic [STRIDE_W-1:0] obj_floor;
  logic [CNT_W-1:0]    cap_sat;
  logic [STRIDE_W-1:0] bitmap;
  logic [STRIDE_W-1:0] bitmap_up;
  logic [ADDR_W-1:0]   offset;

  assign init = cfg_we;
  assign busy = q_full | settle_r;
  assign geom = geom_r;

  always_comb begin
    sh        = (align_log2_r > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : align_log2_r;
    al        = (sh < 4'd3) ? AL_W'(8) : (AL_W'(1) << sh);
    mask      = STRIDE_W'(al) - 1'b1;
    obj_floor = (obj_size_r < OBJ_W'(8)) ? STRIDE_W'(8) : STRIDE_W'(obj_size_r);
    cap_sat   = (capacity_r > MAX_CAP) ? MAX_CAP : capacity_r;
    bitmap    = STRIDE_W'((cap_sat + CNT_W'(7)) >> 3);
    bitmap_up = (bitmap + mask) & ~mask;
    geom_nxt.stride = (obj_floor + mask) & ~mask;
    geom_nxt.region = base_r + ADDR_W'(bitmap_up);
    geom_nxt.cap    = cap_sat;
    geom_nxt.limit  = LIMIT_W'(cap_sat) * LIMIT_W'(geom_nxt.stride);
  end

  always_comb begin
    offset                = in_data.release_address - geom_r.region;
    push                  = start & ~busy;
    push_job.operation    = in_data.operation;
    push_job.is_null      = (in_data.release_address == '0);
    push_job.out_of_range = (offset >= ADDR_W'(geom_r.limit));
    push_job.offset       = offset[OFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_size_r   <= OBJ_W'(8);
      align_log2_r <= ALIGN_W'(3);
      capacity_r   <= MAX_CAP;
      base_r       <= '0;
      settle_r     <= 1'b1;
    end else begin
      settle_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_OBJECT_SIZE:    obj_size_r   <= cfg_wdata[OBJ_W-1:0];
          REG_ALIGNMENT_LOG2: align_log2_r <= cfg_wdata[ALIGN_W-1:0];
          REG_POOL_CAPACITY:  capacity_r   <= cfg_wdata[CNT_W-1:0];
          REG_BACKING_BASE:   base_r       <= cfg_wdata;
          default:            base_r       <= base_r;
        endcase
      end
    end
  end

endmodule

// ===== hdl/fsa_back.sv =====
`timescale 1ns / 1ps
module fsa_back
  import fsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      init,
  input  fsa_geom_t geom,
  input  logic      q_empty,
  input  fsa_job_t  q_job,
  output logic      pop,
  output logic      out_valid,
  output fsa_out_t  out_data
);

  bk_state_t             state_r, state_nxt;
  fsa_job_t              job_r, job_nxt;
  logic [MAX_SLOTS-1:0]  in_use_r, in_use_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      fresh_r, fresh_nxt;
  logic [CNT_W-1:0]      active_r, active_nxt;
  logic [CNT_W-1:0]      peak_r, peak_nxt;
  logic [CTR_W-1:0]      acq_r, acq_nxt;
  logic [CTR_W-1:0]      rel_r, rel_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [OFF_W-1:0]      rem_r, rem_nxt;
  logic [IDX_W-1:0]      quo_r, quo_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic                  out_valid_r, out_valid_nxt;
  fsa_out_t              out_r, out_nxt;

  logic [IDX_W-1:0]      link_mem [MAX_SLOTS];
  logic [IDX_W-1:0]      link_q;
  logic [IDX_W-1:0]      link_ra;
  logic                  link_we;
  logic [IDX_W-1:0]      link_wa;
  logic [IDX_W-1:0]      link_wd;
  logic [PROD_W-1:0]     trial;
  logic                  stacked;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign stacked   = (fresh_r > active_r);

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_q <= link_mem[link_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    in_use_nxt    = in_use_r;
    head_nxt      = head_r;
    fresh_nxt     = fresh_r;
    active_nxt    = active_r;
    peak_nxt      = peak_r;
    acq_nxt       = acq_r;
    rel_nxt       = rel_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    prod_nxt      = prod_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pop           = 1'b0;
    link_ra       = head_r;
    link_we       = 1'b0;
    link_wa       = idx_r;
    link_wd       = head_r;
    trial         = PROD_W'(geom.stride) << step_r;

    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          job_nxt = q_job;
          out_nxt.slot_addr = '0;
          if (q_job.operation == OP_ACQUIRE) begin
            if (active_r >= geom.cap) begin
              out_valid_nxt  = 1'b1;
              out_nxt.status = ST_EMPTY;
            end else if (acq_r == CTR_MAX) begin
              out_valid_nxt  = 1'b1;
              out_nxt.status = ST_OVERFLOW;
            end else begin
              idx_nxt   = stacked ? head_r : fresh_r[IDX_W-1:0];
              state_nxt = BK_ACQ_READ;
            end
          end else if (q_job.is_null) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = ST_NULL;
          end else if (q_job.out_of_range) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = ST_BAD_ADDR;
          end else begin
            rem_nxt   = q_job.offset;
            quo_nxt   = '0;
            step_nxt  = STEP_W'(IDX_W - 1);
            state_nxt = BK_DIV;
          end
        end
      end
      BK_ACQ_READ: begin
        prod_nxt = PROD_W'(idx_r) * PROD_W'(geom.stride);
        if (stacked) begin
          if ((fresh_r - active_r) > CNT_W'(1)) begin
            head_nxt = link_q;
          end
        end else begin
          fresh_nxt = fresh_r + 1'b1;
        end
        in_use_nxt[idx_r] = 1'b1;
        active_nxt = active_r + 1'b1;
        if (active_nxt > peak_r) begin
          peak_nxt = active_nxt;
        end
        acq_nxt   = acq_r + 1'b1;
        state_nxt = BK_ACQ_ADD;
      end
      BK_ACQ_ADD: begin
        out_valid_nxt     = 1'b1;
        out_nxt.status    = ST_OK;
        out_nxt.slot_addr = geom.region + ADDR_W'(prod_r);
        state_nxt         = BK_IDLE;
      end
      BK_DIV: begin
        if (PROD_W'(rem_r) >= trial) begin
          rem_nxt         = rem_r - OFF_W'(trial);
          quo_nxt[step_r] = 1'b1;
        end
        if (step_r == '0) begin
          state_nxt = BK_REL;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      BK_REL: begin
        out_valid_nxt = 1'b1;
        state_nxt     = BK_IDLE;
        if (rem_r != '0) begin
          out_nxt.status = ST_BAD_ADDR;
        end else if (!in_use_r[quo_r]) begin
          out_nxt.status = ST_NOT_ACTIVE;
        end else if (rel_r == CTR_MAX) begin
          out_nxt.status = ST_OVERFLOW;
        end else begin
          out_nxt.status    = ST_OK;
          in_use_nxt[quo_r] = 1'b0;
          link_we           = stacked;
          link_wa           = quo_r;
          head_nxt          = quo_r;
          active_nxt        = active_r - 1'b1;
          rel_nxt           = rel_r + 1'b1;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    out_nxt.active_count     = active_nxt;
    out_nxt.free_count       = geom.cap - active_nxt;
    out_nxt.peak_count       = peak_nxt;
    out_nxt.allocation_total = acq_nxt;
    out_nxt.release_total    = rel_nxt;
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    idx_r  <= idx_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      state_r     <= BK_IDLE;
      in_use_r    <= '0;
      head_r      <= '0;
      fresh_r     <= '0;
      active_r    <= '0;
      peak_r      <= '0;
      acq_r       <= '0;
      rel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      head_r      <= head_nxt;
      fresh_r     <= fresh_nxt;
      active_r    <= active_nxt;
      peak_r      <= peak_nxt;
      acq_r       <= acq_nxt;
      rel_r       <= rel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/fsa_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fsa_checker
  import fsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  busy,
  input  logic                  out_valid,
  input  fsa_out_t              out_data
);

  logic       refused;
  logic [9:0] count_sum;

  assign refused   = out_valid && (out_data.status != ST_OK);
  assign count_sum = 10'(out_data.active_count) + 10'(out_data.free_count);

  // A refused operation never reports a slot address.
  `ASSERT_RUN(a_fail_no_addr, clk, rst_n, refused |-> out_data.slot_addr == '0)
  // The peak never falls below the current active count.
  `ASSERT_RUN(a_peak_covers, clk, rst_n, out_valid |-> out_data.peak_count >= out_data.active_count)
  // Active and free slots together never exceed the slot store.
  `ASSERT_RUN(a_count_sum, clk, rst_n, out_valid |-> count_sum <= 10'(MAX_SLOTS))
  // No transfer leaves the block in the cycle after reset or a configuration write.
  `ASSERT_ALWAYS(a_quiet_after_init, clk, !rst_n || cfg_we |=> !out_valid)
  // The block refuses input in the cycle after reset.
  `ASSERT_ALWAYS(a_busy_after_reset, clk, !rst_n |=> busy)

endmodule

bind fixed_slot_pool_allocator fsa_checker u_fsa_checker (.*);
